// File: rtl/bi2csrf_pkg.sv
package bi2csrf_pkg;

  // Number of register banks; the last one is the shared scratch bank.
  localparam int unsigned BANK_COUNT = 6;

  // Registers per bank and the width of one register.
  localparam int unsigned REGS_PER_BANK = 256;
  localparam int unsigned REG_W         = 8;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [REG_W-1:0] REG_PART_ID_L = 8'h00;
  localparam logic [REG_W-1:0] REG_PART_ID_H = 8'h01;
  localparam logic [REG_W-1:0] REG_TRIGGER   = 8'h30;
  localparam logic [REG_W-1:0] REG_BANK_SEL  = 8'hEF;
  localparam logic [REG_W-1:0] PART_ID_L_VAL = 8'h82;
  localparam logic [REG_W-1:0] PART_ID_H_VAL = 8'h79;

endpackage

// File: rtl/bi2csrf_ram.sv
// Single-port synchronous RAM with a registered read.
module bi2csrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/banked_i2c_sensor_register_file_unit.sv
// Bank-switched register file of an I2C camera-sensor target.
//
// The input channel carries one bus event per item: a start of a write
// transfer, a written byte, a read or none. The output channel returns
// exactly one item per input item, in order: the read byte (zero unless
// the event was a read), the streaming trigger bit and the wrapping
// trigger count. Both channels use valid and stall, and an item moves at
// a rising edge where valid is high and stall is low.
//
// Start and write events place their result in the output register at
// acceptance. A read first passes through the registered memory read in
// ST_READ, and the block takes no new item while it is there. The output
// register holds one result; a new item enters only while no result is
// held or in the cycle the held result is taken, so while the receiver
// stalls, the input stalls.
//
// After reset the block sweeps the register memory with zeros, one entry
// per cycle, all BankCount*256 entries (1536 with six banks), and holds
// in_stall_o high until the sweep is done.
module banked_i2c_sensor_register_file_unit #(
  parameter int unsigned BankCount = bi2csrf_pkg::BANK_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        streaming_o,
  output logic [31:0] trigger_count_o
);

  localparam int unsigned Depth = BankCount * bi2csrf_pkg::REGS_PER_BANK;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned BankW = $clog2(BankCount);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_READ
  } state_e;

  state_e      state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [7:0]  bank_sel_q, bank_sel_d;
  logic [7:0]  ptr_q, ptr_d;
  logic        addr_rcvd_q, addr_rcvd_d;
  logic        trig_q, trig_d;
  logic [31:0] count_q, count_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  rdata_q, rdata_d;
  // A read whose byte does not come from memory keeps its value here.
  logic        fix_sel_q, fix_sel_d;
  logic [7:0]  fix_val_q, fix_val_d;

  logic             accept;
  logic             out_free;
  logic             bank0;
  logic             part_id;
  logic [BankW-1:0] act_bank;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  bi2csrf_pkg::cmd_e cmd;

  assign cmd      = bi2csrf_pkg::cmd_e'(command_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == ST_RUN) && out_free;
  assign in_stall_o = !((state_q == ST_RUN) && out_free);

  // Selectors at or past the bank count all land in the last bank.
  assign act_bank = (int'(bank_sel_q) < BankCount) ? bank_sel_q[BankW-1:0]
                                                   : BankW'(BankCount - 1);
  assign bank0    = (bank_sel_q == 8'd0);
  assign part_id  = bank0 && ((ptr_q == bi2csrf_pkg::REG_PART_ID_L) ||
                              (ptr_q == bi2csrf_pkg::REG_PART_ID_H));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    bank_sel_d  = bank_sel_q;
    ptr_d       = ptr_q;
    addr_rcvd_d = addr_rcvd_q;
    trig_d      = trig_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    rdata_d     = rdata_q;
    fix_sel_d   = fix_sel_q;
    fix_val_d   = fix_val_q;
    ram_we      = 1'b0;
    ram_addr    = {act_bank, ptr_q};
    ram_wdata   = data_in_i;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 8'd0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          rdata_d = 8'd0;
          case (cmd)
            bi2csrf_pkg::CMD_START: begin
              addr_rcvd_d = 1'b0;
              out_valid_d = 1'b1;
            end
            bi2csrf_pkg::CMD_WRITE: begin
              out_valid_d = 1'b1;
              if (!addr_rcvd_q) begin
                // First byte after a start only loads the pointer.
                ptr_d       = data_in_i;
                addr_rcvd_d = 1'b1;
              end else begin
                ptr_d = ptr_q + 8'd1;
                if (ptr_q == bi2csrf_pkg::REG_BANK_SEL) begin
                  bank_sel_d = data_in_i;
                end else if (!part_id) begin
                  ram_we = 1'b1;
                  // Bank 0 register 0x30 is mirrored so the trigger edge
                  // and the streaming bit need no memory read.
                  if (bank0 && (ptr_q == bi2csrf_pkg::REG_TRIGGER)) begin
                    trig_d = data_in_i[0];
                    if (data_in_i[0] && !trig_q) begin
                      count_d = count_q + 32'd1;
                    end
                  end
                end
              end
            end
            bi2csrf_pkg::CMD_READ: begin
              ptr_d     = ptr_q + 8'd1;
              state_d   = ST_READ;
              fix_sel_d = 1'b1;
              if (ptr_q == bi2csrf_pkg::REG_BANK_SEL) begin
                fix_val_d = bank_sel_q;
              end else if (bank0 && (ptr_q == bi2csrf_pkg::REG_PART_ID_L)) begin
                fix_val_d = bi2csrf_pkg::PART_ID_L_VAL;
              end else if (bank0 && (ptr_q == bi2csrf_pkg::REG_PART_ID_H)) begin
                fix_val_d = bi2csrf_pkg::PART_ID_H_VAL;
              end else begin
                fix_sel_d = 1'b0;
                fix_val_d = 8'd0;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        // The output register is empty here: it was free at acceptance.
        rdata_d     = fix_sel_q ? fix_val_q : ram_rdata;
        out_valid_d = 1'b1;
        state_d     = ST_RUN;
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      bank_sel_q  <= 8'd0;
      ptr_q       <= 8'd0;
      addr_rcvd_q <= 1'b0;
      trig_q      <= 1'b0;
      count_q     <= 32'd0;
      out_valid_q <= 1'b0;
      rdata_q     <= 8'd0;
      fix_sel_q   <= 1'b0;
      fix_val_q   <= 8'd0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      bank_sel_q  <= bank_sel_d;
      ptr_q       <= ptr_d;
      addr_rcvd_q <= addr_rcvd_d;
      trig_q      <= trig_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rdata_q     <= rdata_d;
      fix_sel_q   <= fix_sel_d;
      fix_val_q   <= fix_val_d;
    end
  end

  bi2csrf_ram #(
    .Width (bi2csrf_pkg::REG_W),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Streaming bit and count are taken from the live state; a read leaves
  // both unchanged, so they match the state after the item's update.
  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rdata_q;
  assign streaming_o     = trig_q;
  assign trigger_count_o = count_q;

endmodule
